FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the scanline unfilter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PUF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PUF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PUF_ASSERT(lbl, clk, rst, prop, msg)
`define PUF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/puf_pkg.sv
// Shared types, filter codes, register indexes and the Paeth predictor of the scanline unfilter.
package puf_pkg;

  localparam int LINE_BYTES_DEF  = 8192;
  localparam int PIXEL_BYTES_DEF = 8;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic REG_LINE_LENGTH     = 1'b0;
  localparam logic REG_BYTES_PER_PIXEL = 1'b1;

  localparam int LEN_W = 14;
  localparam int BPP_W = 4;

  // data byte in flight between the sequencer and the reconstruct stage
  typedef struct packed {
    logic [7:0] code;
    logic [2:0] kind;
    logic       first_row;
    logic       last;
  } puf_item_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

FILE: hw/rtl/puf_line_mem.sv
// Previous-scanline store: one write port, one registered read port, write-first.
module puf_line_mem #(
  parameter int DEPTH = puf_pkg::LINE_BYTES_DEF,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      // same-column write in this cycle: hand the new byte straight over
      rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/puf_seq.sv
// Input sequencer: filter byte / column tracking, line store read, first pipeline stage.
module puf_seq #(
  parameter int LINE_BYTES = puf_pkg::LINE_BYTES_DEF,
  parameter int COL_W      = 13
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_byte,
  input  logic                      s_frame_start,
  input  logic [puf_pkg::LEN_W-1:0] line_length,
  input  logic                      take,
  output logic                      rd_en,
  output logic [COL_W-1:0]          rd_addr,
  output logic                      s1_valid,
  output puf_pkg::puf_item_t        s1_item,
  output logic [COL_W-1:0]          s1_col
);
  import puf_pkg::*;

  localparam int CMP_W = (COL_W + 1 > LEN_W) ? COL_W + 1 : LEN_W;

  logic [COL_W-1:0] column;
  logic             expect_filt;
  logic [2:0]       kind;
  logic             first_row;

  logic             fire;
  logic             filt_now;
  logic [COL_W:0]   col_inc;
  logic             last;

  assign s_tready = !s1_valid || take;
  assign fire     = s_tvalid && s_tready;
  assign filt_now = expect_filt || s_frame_start;
  assign col_inc  = {1'b0, column} + 1'b1;
  assign last     = (CMP_W'(col_inc) >= CMP_W'(line_length))
                 || (CMP_W'(col_inc) == CMP_W'(LINE_BYTES));
  assign rd_en    = fire && !filt_now;
  assign rd_addr  = column;

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      expect_filt <= 1'b1;
      kind        <= FILT_NONE;
      first_row   <= 1'b1;
      s1_valid    <= 1'b0;
    end else begin
      if (fire && filt_now) begin
        kind        <= (s_byte <= 8'(FILT_PAETH)) ? s_byte[2:0] : FILT_NONE;
        expect_filt <= 1'b0;
        column      <= '0;
        first_row   <= first_row || s_frame_start;
      end else if (fire) begin
        if (last) begin
          column      <= '0;
          expect_filt <= 1'b1;
          first_row   <= 1'b0;
        end else begin
          column <= col_inc[COL_W-1:0];
        end
      end
      if (rd_en) begin
        s1_valid <= 1'b1;
      end else if (take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_item.code      <= s_byte;
      s1_item.kind      <= kind;
      s1_item.first_row <= first_row;
      s1_item.last      <= last;
      s1_col            <= column;
    end
  end

endmodule

FILE: hw/rtl/puf_recon.sv
// Reconstruct stage: neighbor histories, filter predictors and the output register.
module puf_recon #(
  parameter int PIXEL_BYTES = puf_pkg::PIXEL_BYTES_DEF,
  parameter int COL_W       = 13
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s1_valid,
  input  puf_pkg::puf_item_t        s1_item,
  input  logic [COL_W-1:0]          s1_col,
  input  logic [7:0]                up_raw,
  input  logic [puf_pkg::BPP_W-1:0] bytes_per_pixel,
  output logic                      take,
  output logic                      wr_en,
  output logic [COL_W-1:0]          wr_addr,
  output logic [7:0]                wr_data,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_pixel,
  output logic                      m_last
);
  import puf_pkg::*;

  localparam int HIST_W = (PIXEL_BYTES > 1) ? $clog2(PIXEL_BYTES) : 1;
  localparam int HL_W   = (COL_W > BPP_W) ? COL_W : BPP_W;

  logic [7:0] left_hist [PIXEL_BYTES];
  logic [7:0] up_hist   [PIXEL_BYTES];

  logic             advance;
  logic [BPP_W-1:0] bpp_eff;
  logic [HIST_W-1:0] hidx;
  logic             has_left;
  logic [7:0]       up;
  logic [7:0]       left;
  logic [7:0]       upleft;
  logic [8:0]       avg_sum;
  logic [7:0]       pred;
  logic [7:0]       raw;

  assign take    = !m_tvalid || m_tready;
  assign advance = s1_valid && take;

  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bytes_per_pixel > BPP_W'(PIXEL_BYTES)) begin
      bpp_eff = BPP_W'(PIXEL_BYTES);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
  end

  assign hidx     = HIST_W'(bpp_eff - 1'b1);
  assign has_left = HL_W'(s1_col) >= HL_W'(bpp_eff);
  assign up       = s1_item.first_row ? 8'd0 : up_raw;
  assign left     = has_left ? left_hist[hidx] : 8'd0;
  assign upleft   = (has_left && !s1_item.first_row) ? up_hist[hidx] : 8'd0;
  assign avg_sum  = {1'b0, left} + {1'b0, up};

  always_comb begin
    case (s1_item.kind)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth_pick(left, up, upleft);
      default:    pred = 8'd0;
    endcase
  end

  assign raw     = s1_item.code + pred;
  assign wr_en   = advance;
  assign wr_addr = s1_col;
  assign wr_data = raw;

  // histories are only read once this row has pushed enough bytes, so no clear on a new row
  always_ff @(posedge clk) begin
    if (advance) begin
      left_hist[0] <= raw;
      up_hist[0]   <= up;
      for (int i = 1; i < PIXEL_BYTES; i++) begin
        left_hist[i] <= left_hist[i-1];
        up_hist[i]   <= up_hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_pixel <= raw;
      m_last  <= s1_item.last;
    end
  end

endmodule

FILE: hw/rtl/png_scanline_unfilter_core.sv
// PNG scanline unfilter top level: config registers, sequencer, line store, reconstruct stage.
// Throughput: one stream byte per cycle unless the output stalls, filter bytes included
// (one line store read port). Data bytes reach m_tvalid via the s1 and output registers.
// Filter bytes give no result; a stalled output holds at most one more byte in flight.
// Reset clears the control state and sets line_length and bytes_per_pixel to 1.
// The line store is not cleared; the first row of an image ignores what it reads.
`include "assert_macros.svh"

module png_scanline_unfilter_core #(
  parameter int LINE_BYTES  = puf_pkg::LINE_BYTES_DEF,
  parameter int PIXEL_BYTES = puf_pkg::PIXEL_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] stream_byte
  input  logic                      s_tuser,   // [0] frame_start
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // [7:0] pixel_byte
  output logic                      m_tlast,   // line_end
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [puf_pkg::LEN_W-1:0] cfg_data
);
  import puf_pkg::*;

  localparam int COL_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  logic [LEN_W-1:0] line_length;
  logic [BPP_W-1:0] bytes_per_pixel;

  logic             take;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             s1_valid;
  puf_item_t        s1_item;
  logic [COL_W-1:0] s1_col;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [7:0]       wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= LEN_W'(1);
      bytes_per_pixel <= BPP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_LENGTH:     line_length     <= cfg_data;
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  puf_seq #(
    .LINE_BYTES (LINE_BYTES),
    .COL_W      (COL_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_byte        (s_tdata),
    .s_frame_start (s_tuser),
    .line_length   (line_length),
    .take          (take),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .s1_valid      (s1_valid),
    .s1_item       (s1_item),
    .s1_col        (s1_col)
  );

  puf_line_mem #(
    .DEPTH (LINE_BYTES),
    .AW    (COL_W)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  puf_recon #(
    .PIXEL_BYTES (PIXEL_BYTES),
    .COL_W       (COL_W)
  ) u_recon (
    .clk             (clk),
    .rst             (rst),
    .s1_valid        (s1_valid),
    .s1_item         (s1_item),
    .s1_col          (s1_col),
    .up_raw          (rd_data),
    .bytes_per_pixel (bytes_per_pixel),
    .take            (take),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_pixel         (m_tdata),
    .m_last          (m_tlast)
  );

  `PUF_ASSERT(a_stall_only_when_full, clk, rst, !s_tready |-> (m_tvalid && !m_tready), "input stalled while output can drain")
  `PUF_ASSERT(a_out_from_stage, clk, rst, $rose(m_tvalid) |-> $past(s1_valid), "result appeared with no item in flight")
  `PUF_ASSERT(a_write_on_advance, clk, rst, wr_en |-> (s1_valid && (!m_tvalid || m_tready)), "line store written without an item advancing")
  `PUF_ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready, "config port not ready")

endmodule

FILE: tb/sv/png_unfilter_checker.sv
`timescale 1ns / 100ps
// Checker for the scanline unfilter: mirrors filter reconstruction and compares each output item.
module png_unfilter_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [7:0]                s_tdata,
  input  logic                      s_tuser,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [7:0]                m_tdata,
  input  logic                      m_tlast,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [puf_pkg::LEN_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending,
  output int                        result_count
);
  import puf_pkg::*;

  localparam int LINE_MAX = LINE_BYTES_DEF;
  localparam int PIX_MAX  = PIXEL_BYTES_DEF;

  typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
  } pixel_item_t;

  pixel_item_t      pixel_q[$];
  logic [LEN_W-1:0] len_reg;
  logic [BPP_W-1:0] bpp_reg;
  logic [7:0]       line_mem [LINE_MAX];
  logic [7:0]       left_hist [PIX_MAX];
  logic [7:0]       upleft_hist [PIX_MAX];
  int unsigned      col_q;
  logic             want_filter;
  logic [2:0]       kind;
  logic             first_row;

  function automatic int unsigned eff_len(input logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > LINE_MAX) return LINE_MAX;
    return 32'(v);
  endfunction

  function automatic int unsigned eff_bpp(input logic [BPP_W-1:0] v);
    if (v == 0) return 1;
    if (v > PIX_MAX) return PIX_MAX;
    return 32'(v);
  endfunction

  function automatic logic [7:0] paeth_choose(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    int p;
    int da;
    int db;
    int dc;
    p  = int'(a) + int'(b) - int'(c);
    da = p - int'(a);
    db = p - int'(b);
    dc = p - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  task automatic unfilter_step(input logic [7:0] code, input logic fs);
    int unsigned len;
    int unsigned bpp;
    int unsigned col;
    logic [7:0]  left;
    logic [7:0]  up;
    logic [7:0]  ul;
    logic [7:0]  pred;
    logic [7:0]  raw;
    logic [8:0]  sum;
    logic        has_left;
    logic        last;
    pixel_item_t item_new;
    len = eff_len(len_reg);
    bpp = eff_bpp(bpp_reg);
    if (fs) begin
      want_filter = 1'b1;
      first_row   = 1'b1;
    end
    if (want_filter) begin
      kind        = (code <= 8'(FILT_PAETH)) ? code[2:0] : FILT_NONE;
      want_filter = 1'b0;
      col_q       = 0;
      for (int i = 0; i < PIX_MAX; i++) begin
        left_hist[i]   = 8'h00;
        upleft_hist[i] = 8'h00;
      end
      return;
    end
    col      = col_q;
    has_left = col >= bpp;
    up       = first_row ? 8'h00 : line_mem[col];
    left     = has_left ? left_hist[bpp-1] : 8'h00;
    ul       = (has_left && !first_row) ? upleft_hist[bpp-1] : 8'h00;
    case (kind)
      FILT_SUB: begin
        pred = left;
      end
      FILT_UP: begin
        pred = up;
      end
      FILT_AVG: begin
        sum  = {1'b0, left} + {1'b0, up};
        pred = sum[8:1];
      end
      FILT_PAETH: begin
        pred = paeth_choose(left, up, ul);
      end
      default: begin
        pred = 8'h00;
      end
    endcase
    raw = code + pred;
    line_mem[col] = raw;
    for (int i = PIX_MAX - 1; i > 0; i--) begin
      left_hist[i]   = left_hist[i-1];
      upleft_hist[i] = upleft_hist[i-1];
    end
    left_hist[0]   = raw;
    upleft_hist[0] = up;
    last = (col + 1) >= len;
    if (last) begin
      col_q       = 0;
      want_filter = 1'b1;
      first_row   = 1'b0;
    end else begin
      col_q = col + 1;
    end
    item_new.pixel    = raw;
    item_new.line_end = last;
    pixel_q = {pixel_q, item_new};
  endtask

  always @(posedge clk) begin
    pixel_item_t want_item;
    if (rst) begin
      len_reg      = LEN_W'(1);
      bpp_reg      = BPP_W'(1);
      col_q        = 0;
      want_filter  = 1'b1;
      kind         = FILT_NONE;
      first_row    = 1'b1;
      fail_count   = 0;
      result_count = 0;
      pixel_q.delete();
      for (int i = 0; i < LINE_MAX; i++) line_mem[i] = 8'h00;
      for (int i = 0; i < PIX_MAX; i++) begin
        left_hist[i]   = 8'h00;
        upleft_hist[i] = 8'h00;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LINE_LENGTH) begin
          len_reg = cfg_data;
        end else begin
          bpp_reg = cfg_data[BPP_W-1:0];
        end
      end
      if (s_tvalid && s_tready) unfilter_step(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        result_count++;
        if (pixel_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output item, got pixel %02h last %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          want_item = pixel_q.pop_front();
          if (want_item.pixel !== m_tdata || want_item.line_end !== m_tlast) begin
            fail_count++;
            $display("%0t: mismatch, expected pixel %02h last %0b, got pixel %02h last %0b",
                     $time, want_item.pixel, want_item.line_end, m_tdata, m_tlast);
          end
        end
      end
    end
    pending = pixel_q.size();
  end

endmodule

FILE: tb/sv/png_scanline_unfilter_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the scanline unfilter: stimulus, flow control, timeout and verdict.
module png_scanline_unfilter_core_tb;
  import puf_pkg::*;

  localparam int RANDOM_ITEMS = 1920;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 10;
  localparam int CYCLE_LIMIT  = 1000000;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;
  logic             s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [7:0]       m_tdata;
  logic             m_tlast;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [LEN_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int result_count;
  int cycles = 0;
  int items_sent;
  int cfg_writes;
  int hold_reqs;
  int holds_done;
  int burst_left;
  bit gaps_on;

  // stream position as the block sees it, used to shape well-formed lines
  int unsigned pos_col;
  int unsigned cur_len;
  bit          pos_filter;
  bit          force_frame;

  png_scanline_unfilter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  png_unfilter_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] pick_filter();
    logic [7:0] v;
    if ($urandom_range(0, 99) < 85) v = 8'($urandom_range(0, 4));
    else v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  task automatic send_item(input logic [7:0] code, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tdata  = code;
    s_tuser  = fs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (fs) force_frame = 1'b0;
    if (fs || pos_filter) begin
      pos_filter = 1'b0;
      pos_col    = 0;
    end else if (pos_col + 1 >= cur_len) begin
      pos_filter = 1'b1;
      pos_col    = 0;
    end else begin
      pos_col++;
    end
  endtask

  task automatic send_auto(input bit noise);
    logic [7:0] code;
    logic       fs;
    fs = force_frame || (noise && $urandom_range(0, 99) < 2);
    if (fs || pos_filter) code = pick_filter();
    else code = 8'($urandom_range(0, 255));
    send_item(code, fs);
  endtask

  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] value);
    int unsigned new_len;
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
    if (idx == REG_LINE_LENGTH) begin
      new_len = (value == 0) ? 1 : (value > LINE_BYTES_DEF) ? LINE_BYTES_DEF : value;
      // a longer line would read store entries the last row never wrote
      if (new_len > cur_len) force_frame = 1'b1;
      cur_len = new_len;
    end
  endtask

  task automatic write_bpp(input logic [BPP_W-1:0] bpp);
    logic [LEN_W-1:0] value;
    value = LEN_W'($urandom_range(0, 16383));
    value[BPP_W-1:0] = bpp;
    write_reg(REG_BYTES_PER_PIXEL, value);
  endtask

  // receiver: random stall patterns, plus long hold-offs on request
  initial begin
    int rx_mode;
    int rx_left;
    int rx_phase;
    m_tready   = 1'b0;
    holds_done = 0;
    rx_mode    = 0;
    rx_left    = 0;
    rx_phase   = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        m_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end else begin
        if (rx_left == 0) begin
          rx_mode  = $urandom_range(0, 3);
          rx_left  = $urandom_range(16, 160);
          rx_phase = 0;
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
          0: m_tready = 1'b1;
          1: m_tready = ($urandom_range(0, 99) >= 30);
          2: m_tready = ((rx_phase % 5) < 3);
          default: m_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int               rand_count;
    int               phase_items;
    int               pick;
    logic [LEN_W-1:0] len_val;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    s_tuser     = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_LINE_LENGTH;
    cfg_data    = '0;
    hold_reqs   = 0;
    items_sent  = 0;
    cfg_writes  = 0;
    burst_left  = 0;
    gaps_on     = 1'b0;
    pos_col     = 0;
    cur_len     = 1;
    pos_filter  = 1'b1;
    force_frame = 1'b0;
    rand_count  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // one-byte lines at reset values: Paeth, Sub, Up, Average and Paeth filters, then unknown codes
    send_item({5'd0, FILT_PAETH}, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item({5'd0, FILT_SUB}, 1'b0);
    send_item(8'h00, 1'b0);
    send_item({5'd0, FILT_UP}, 1'b0);
    send_item(8'h80, 1'b0);
    send_item({5'd0, FILT_AVG}, 1'b0);
    send_item(8'h01, 1'b0);
    send_item({5'd0, FILT_PAETH}, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h05, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h55, 1'b0);
    // zero registers act as one
    write_reg(REG_LINE_LENGTH, '0);
    write_bpp('0);
    send_item({5'd0, FILT_AVG}, 1'b1);
    send_item(8'hFE, 1'b0);
    // pixel width above the maximum, then a frame start in the middle of a line
    write_reg(REG_LINE_LENGTH, 14'd4);
    write_reg(REG_BYTES_PER_PIXEL, '1);
    send_item({5'd0, FILT_SUB}, 1'b1);
    send_item(8'h10, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'hC3, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item({5'd0, FILT_PAETH}, 1'b0);
    send_item(8'h3C, 1'b0);
    send_item(8'h01, 1'b0);
    send_item({5'd0, FILT_NONE}, 1'b1);
    send_item(8'h99, 1'b0);

    gaps_on = 1'b1;
    while (rand_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) len_val = LEN_W'($urandom_range(1, 16));
      else if (pick < 85) len_val = LEN_W'($urandom_range(17, 64));
      else if (pick < 95) len_val = LEN_W'($urandom_range(65, 400));
      else len_val = LEN_W'($urandom_range(0, 1));
      write_reg(REG_LINE_LENGTH, len_val);
      if ($urandom_range(0, 99) < 85) write_bpp(BPP_W'($urandom_range(1, 8)));
      else write_bpp(BPP_W'($urandom_range(0, 15)));
      if ($urandom_range(0, 1) == 1) force_frame = 1'b1;
      phase_items = $urandom_range(20, 250);
      for (int k = 0; k < phase_items && rand_count < RANDOM_ITEMS; k++) begin
        if (rand_count == 300 || rand_count == 1200) hold_reqs++;
        // drained pause, often mid-line, with a register change
        if (rand_count == 700 || $urandom_range(0, 199) == 0) begin
          if ($urandom_range(0, 1) == 1) write_bpp(BPP_W'($urandom_range(0, 15)));
          else write_reg(REG_LINE_LENGTH, LEN_W'($urandom_range(0, cur_len)));
        end
        send_auto(1'b1);
        rand_count++;
      end
    end

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("sent %0d stream items, checked %0d output items, %0d register writes",
             items_sent, result_count, cfg_writes);
    $display("line lengths 0..400, pixel widths 0..15, all filters, unknown codes, frame drops");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
